### hw/rtl/robot_motion_safety_interlock_core_assert.svh
// Assertion macros used by the checker file.
`ifndef ROBOT_MOTION_SAFETY_INTERLOCK_CORE_ASSERT_SVH
`define ROBOT_MOTION_SAFETY_INTERLOCK_CORE_ASSERT_SVH

// Check a property on clk, skipped while reset is high.
`define RMSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on clk, also while reset is high.
`define RMSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rmsi_pkg.sv
package rmsi_pkg;

  // Widths
  localparam int VELOCITY_WIDTH_DEF = 16;
  localparam int CFG_WIDTH          = 16;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int CMD_WIDTH          = 2;
  localparam int CLIFF_WIDTH        = 2;
  localparam int READING_WIDTH      = 16;
  localparam int TICK_WIDTH         = 16;
  localparam int HAZARD_WIDTH       = 6;

  // Item selector
  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_VELOCITY = 2'd0,
    CMD_CONTROL  = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_EDGE_THRESHOLD     = 2'd0,
    CFG_OBSTACLE_THRESHOLD = 2'd1,
    CFG_COMMAND_TIMEOUT    = 2'd2
  } cfg_index_t;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] EDGE_THRESHOLD_RST     = 16'd100;
  localparam logic [CFG_WIDTH-1:0] OBSTACLE_THRESHOLD_RST = 16'd650;
  localparam logic [CFG_WIDTH-1:0] COMMAND_TIMEOUT_RST    = 16'd500;

  // Disconnected reading and watchdog saturation
  localparam logic [READING_WIDTH-1:0] READING_DISCONNECTED = 16'hffff;
  localparam logic [TICK_WIDTH-1:0]    TICK_MAX             = 16'hffff;

  // Cliff flag bits
  localparam int CLIFF_REAR  = 0;
  localparam int CLIFF_FRONT = 1;

  // Hazard bits: FR, RR, RL, FL, top rear, top front
  localparam int HZ_FR = 0;
  localparam int HZ_RR = 1;
  localparam int HZ_RL = 2;
  localparam int HZ_FL = 3;
  localparam int HZ_TR = 4;
  localparam int HZ_TF = 5;

  // Sensor groups that block each drive direction
  localparam logic [HAZARD_WIDTH-1:0] HZ_BLOCK_FORWARD  = 6'b101001;
  localparam logic [HAZARD_WIDTH-1:0] HZ_BLOCK_BACKWARD = 6'b010110;
  localparam logic [HAZARD_WIDTH-1:0] HZ_BLOCK_ROT_POS  = 6'b001010;
  localparam logic [HAZARD_WIDTH-1:0] HZ_BLOCK_ROT_NEG  = 6'b000101;

  // A sensor trips on a floor edge, a close obstacle or a lost connection
  function automatic logic sensor_trips(
    input logic [READING_WIDTH-1:0] reading,
    input logic [CFG_WIDTH-1:0]     edge_thr,
    input logic [CFG_WIDTH-1:0]     obstacle_thr
  );
    return (reading < edge_thr) || (reading > obstacle_thr) ||
           (reading == READING_DISCONNECTED);
  endfunction

endpackage

### hw/rtl/rmsi_if.sv
// Input item channel
interface rmsi_cmd_if #(
  parameter int VELOCITY_WIDTH = rmsi_pkg::VELOCITY_WIDTH_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic [rmsi_pkg::CMD_WIDTH-1:0]          command;
  logic signed [VELOCITY_WIDTH-1:0]        linear_request;
  logic signed [VELOCITY_WIDTH-1:0]        rotation_request;
  logic                                    hub_ok;
  logic [rmsi_pkg::CLIFF_WIDTH-1:0]        cliff_flags;
  logic [rmsi_pkg::READING_WIDTH-1:0]      ir_front_right;
  logic [rmsi_pkg::READING_WIDTH-1:0]      ir_rear_right;
  logic [rmsi_pkg::READING_WIDTH-1:0]      ir_rear_left;
  logic [rmsi_pkg::READING_WIDTH-1:0]      ir_front_left;
  logic                                    imu_ok;

  modport source (
    output valid, command, linear_request, rotation_request, hub_ok, cliff_flags,
           ir_front_right, ir_rear_right, ir_rear_left, ir_front_left, imu_ok,
    input  ready
  );
  modport sink (
    input  valid, command, linear_request, rotation_request, hub_ok, cliff_flags,
           ir_front_right, ir_rear_right, ir_rear_left, ir_front_left, imu_ok,
    output ready
  );
endinterface

// Result item channel
interface rmsi_drive_if #(
  parameter int VELOCITY_WIDTH = rmsi_pkg::VELOCITY_WIDTH_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic                                    drive_valid;
  logic signed [VELOCITY_WIDTH-1:0]        linear_drive;
  logic signed [VELOCITY_WIDTH-1:0]        rotation_drive;
  logic                                    drive_enable;
  logic                                    drive_halt;
  logic                                    estop_latched;
  logic                                    all_clear;
  logic [rmsi_pkg::HAZARD_WIDTH-1:0]       hazard_mask;
  logic [rmsi_pkg::HAZARD_WIDTH-1:0]       new_hazard_mask;
  logic [rmsi_pkg::HAZARD_WIDTH-1:0]       cleared_mask;

  modport source (
    output valid, drive_valid, linear_drive, rotation_drive, drive_enable, drive_halt,
           estop_latched, all_clear, hazard_mask, new_hazard_mask, cleared_mask,
    input  ready
  );
  modport sink (
    input  valid, drive_valid, linear_drive, rotation_drive, drive_enable, drive_halt,
           estop_latched, all_clear, hazard_mask, new_hazard_mask, cleared_mask,
    output ready
  );
endinterface

### hw/rtl/robot_motion_safety_interlock_core.sv
// Channel   Dir  Contents
// cmd       in   command, velocity request, hub/imu status, cliff flags, 4 IR readings
// drive     out  gated velocities, enable/halt, stop latch, hazard masks
// cfg_*     in   register write: cfg_we, cfg_index, cfg_data
//
// Throughput is one beat per clock while drive does not stall; each beat passes
// through the input register and then the result register, with all interlock logic in the single stage between them.
// Synchronous active-high reset clears the stop latch, targets, hazards, watchdog
// and configuration registers to their defaults. A stall on drive backs up through both
// registers to cmd.ready; no beat is dropped or repeated.
module robot_motion_safety_interlock_core #(
  parameter int VELOCITY_WIDTH = rmsi_pkg::VELOCITY_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rmsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rmsi_pkg::CFG_WIDTH-1:0]       cfg_data,
  rmsi_cmd_if.sink                             cmd,
  rmsi_drive_if.source                         drive
);

  localparam int VW = VELOCITY_WIDTH;
  localparam int HW = rmsi_pkg::HAZARD_WIDTH;

  // Configuration registers
  logic [rmsi_pkg::CFG_WIDTH-1:0] edge_thr;
  logic [rmsi_pkg::CFG_WIDTH-1:0] obstacle_thr;
  logic [rmsi_pkg::CFG_WIDTH-1:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_thr      <= rmsi_pkg::EDGE_THRESHOLD_RST;
      obstacle_thr  <= rmsi_pkg::OBSTACLE_THRESHOLD_RST;
      timeout_ticks <= rmsi_pkg::COMMAND_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmsi_pkg::CFG_EDGE_THRESHOLD:     edge_thr      <= cfg_data;
        rmsi_pkg::CFG_OBSTACLE_THRESHOLD: obstacle_thr  <= cfg_data;
        rmsi_pkg::CFG_COMMAND_TIMEOUT:    timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  logic s1_valid;
  logic out_valid;
  logic s2_free;
  logic s1_adv;

  assign s2_free   = !out_valid || drive.ready;
  assign s1_adv    = s1_valid && s2_free;
  assign cmd.ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (drive.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register
  logic [rmsi_pkg::CMD_WIDTH-1:0]     s1_command;
  logic [VW-1:0]                      s1_lin;
  logic [VW-1:0]                      s1_rot;
  logic                               s1_hub;
  logic [rmsi_pkg::CLIFF_WIDTH-1:0]   s1_cliff;
  logic [rmsi_pkg::READING_WIDTH-1:0] s1_ir_fr;
  logic [rmsi_pkg::READING_WIDTH-1:0] s1_ir_rr;
  logic [rmsi_pkg::READING_WIDTH-1:0] s1_ir_rl;
  logic [rmsi_pkg::READING_WIDTH-1:0] s1_ir_fl;
  logic                               s1_imu;

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_command <= cmd.command;
      s1_lin     <= cmd.linear_request;
      s1_rot     <= cmd.rotation_request;
      s1_hub     <= cmd.hub_ok;
      s1_cliff   <= cmd.cliff_flags;
      s1_ir_fr   <= cmd.ir_front_right;
      s1_ir_rr   <= cmd.ir_rear_right;
      s1_ir_rl   <= cmd.ir_rear_left;
      s1_ir_fl   <= cmd.ir_front_left;
      s1_imu     <= cmd.imu_ok;
    end
  end

  // Interlock state
  logic                                estop;
  logic [VW-1:0]                       lin_target;
  logic [VW-1:0]                       rot_target;
  logic [HW-1:0]                       active_hazards;
  logic                                clear_flag;
  logic [rmsi_pkg::TICK_WIDTH-1:0]     ticks;

  logic                                estop_next;
  logic [VW-1:0]                       lin_target_next;
  logic [VW-1:0]                       rot_target_next;
  logic [HW-1:0]                       active_hazards_next;
  logic                                clear_flag_next;
  logic [rmsi_pkg::TICK_WIDTH-1:0]     ticks_next;

  // Sensor trips; top cliff sensors read zero on a cliff, else the edge level
  logic [rmsi_pkg::READING_WIDTH-1:0] top_rear_rd;
  logic [rmsi_pkg::READING_WIDTH-1:0] top_front_rd;
  logic [HW-1:0]                      trig;

  assign top_rear_rd  = s1_cliff[rmsi_pkg::CLIFF_REAR]  ? '0 : edge_thr;
  assign top_front_rd = s1_cliff[rmsi_pkg::CLIFF_FRONT] ? '0 : edge_thr;

  always_comb begin
    trig                  = '0;
    trig[rmsi_pkg::HZ_FR] = rmsi_pkg::sensor_trips(s1_ir_fr, edge_thr, obstacle_thr);
    trig[rmsi_pkg::HZ_RR] = rmsi_pkg::sensor_trips(s1_ir_rr, edge_thr, obstacle_thr);
    trig[rmsi_pkg::HZ_RL] = rmsi_pkg::sensor_trips(s1_ir_rl, edge_thr, obstacle_thr);
    trig[rmsi_pkg::HZ_FL] = rmsi_pkg::sensor_trips(s1_ir_fl, edge_thr, obstacle_thr);
    trig[rmsi_pkg::HZ_TR] = rmsi_pkg::sensor_trips(top_rear_rd, edge_thr, obstacle_thr);
    trig[rmsi_pkg::HZ_TF] = rmsi_pkg::sensor_trips(top_front_rd, edge_thr, obstacle_thr);
  end

  // Direction gating: zero each velocity that points toward a tripped sensor
  logic [VW-1:0] lin_base;
  logic [VW-1:0] rot_base;
  logic          lin_pos;
  logic          lin_neg;
  logic          rot_pos;
  logic          rot_neg;
  logic          lin_block;
  logic          rot_block;
  logic [VW-1:0] lin_gated;
  logic [VW-1:0] rot_gated;

  assign lin_base  = estop ? '0 : lin_target;
  assign rot_base  = estop ? '0 : rot_target;
  assign lin_neg   = lin_base[VW-1];
  assign lin_pos   = (lin_base != '0) && !lin_base[VW-1];
  assign rot_neg   = rot_base[VW-1];
  assign rot_pos   = (rot_base != '0) && !rot_base[VW-1];
  assign lin_block = (((trig & rmsi_pkg::HZ_BLOCK_FORWARD) != '0) && lin_pos) ||
                     (((trig & rmsi_pkg::HZ_BLOCK_BACKWARD) != '0) && lin_neg);
  assign rot_block = (((trig & rmsi_pkg::HZ_BLOCK_ROT_POS) != '0) && rot_pos) ||
                     (((trig & rmsi_pkg::HZ_BLOCK_ROT_NEG) != '0) && rot_neg);
  assign lin_gated = lin_block ? '0 : lin_base;
  assign rot_gated = rot_block ? '0 : rot_base;

  // Watchdog count, saturating
  logic [rmsi_pkg::TICK_WIDTH-1:0] tick_inc;
  assign tick_inc = (ticks == rmsi_pkg::TICK_MAX) ? ticks : ticks + 1'b1;

  // Result fields
  logic          res_drive_valid;
  logic [VW-1:0] res_lin;
  logic [VW-1:0] res_rot;
  logic          res_enable;
  logic          res_halt;
  logic [HW-1:0] res_new;
  logic [HW-1:0] res_cleared;
  logic          drive_stop;

  // Next state and result for the item in the input register
  always_comb begin
    estop_next          = estop;
    lin_target_next     = lin_target;
    rot_target_next     = rot_target;
    active_hazards_next = active_hazards;
    clear_flag_next     = clear_flag;
    ticks_next          = ticks;
    res_drive_valid     = 1'b0;
    res_lin             = '0;
    res_rot             = '0;
    res_enable          = 1'b0;
    res_halt            = 1'b0;
    res_new             = '0;
    res_cleared         = '0;
    drive_stop          = 1'b0;
    unique case (s1_command)
      rmsi_pkg::CMD_VELOCITY: begin
        if (estop && (s1_lin == '0) && clear_flag) begin
          estop_next = 1'b0;
        end
        lin_target_next = s1_lin;
        rot_target_next = s1_rot;
        ticks_next      = '0;
      end
      rmsi_pkg::CMD_TICK: begin
        ticks_next = tick_inc;
        if ((tick_inc >= timeout_ticks) && !estop) begin
          estop_next      = 1'b1;
          lin_target_next = '0;
          rot_target_next = '0;
        end
      end
      rmsi_pkg::CMD_CONTROL: begin
        res_drive_valid = 1'b1;
        if (s1_hub) begin
          drive_stop          = estop || (trig != '0);
          res_lin             = lin_gated;
          res_rot             = rot_gated;
          res_new             = trig & ~active_hazards;
          res_cleared         = active_hazards & ~trig;
          active_hazards_next = trig;
          clear_flag_next     = (trig == '0);
        end else begin
          // Hub lost: halt at once, keep hazards
          if (!estop) begin
            estop_next      = 1'b1;
            res_halt        = 1'b1;
            lin_target_next = '0;
            rot_target_next = '0;
          end
          drive_stop = 1'b1;
        end
        res_enable = !drive_stop;
        // IMU lost: latch after the drive update
        if (!s1_imu && !estop_next) begin
          estop_next      = 1'b1;
          res_halt        = 1'b1;
          lin_target_next = '0;
          rot_target_next = '0;
        end
      end
      default: ;
    endcase
  end

  // Commit state as the beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      estop          <= 1'b0;
      lin_target     <= '0;
      rot_target     <= '0;
      active_hazards <= '0;
      clear_flag     <= 1'b0;
      ticks          <= '0;
    end else if (s1_adv) begin
      estop          <= estop_next;
      lin_target     <= lin_target_next;
      rot_target     <= rot_target_next;
      active_hazards <= active_hazards_next;
      clear_flag     <= clear_flag_next;
      ticks          <= ticks_next;
    end
  end

  // Result register
  logic          out_drive_valid;
  logic [VW-1:0] out_lin;
  logic [VW-1:0] out_rot;
  logic          out_enable;
  logic          out_halt;
  logic          out_estop;
  logic          out_clear;
  logic [HW-1:0] out_hazards;
  logic [HW-1:0] out_new;
  logic [HW-1:0] out_cleared;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_drive_valid <= res_drive_valid;
      out_lin         <= res_lin;
      out_rot         <= res_rot;
      out_enable      <= res_enable;
      out_halt        <= res_halt;
      out_estop       <= estop_next;
      out_clear       <= clear_flag_next;
      out_hazards     <= active_hazards_next;
      out_new         <= res_new;
      out_cleared     <= res_cleared;
    end
  end

  assign drive.valid           = out_valid;
  assign drive.drive_valid     = out_drive_valid;
  assign drive.linear_drive    = out_lin;
  assign drive.rotation_drive  = out_rot;
  assign drive.drive_enable    = out_enable;
  assign drive.drive_halt      = out_halt;
  assign drive.estop_latched   = out_estop;
  assign drive.all_clear       = out_clear;
  assign drive.hazard_mask     = out_hazards;
  assign drive.new_hazard_mask = out_new;
  assign drive.cleared_mask    = out_cleared;

endmodule

### hw/rtl/rmsi_checker.sv
`include "robot_motion_safety_interlock_core_assert.svh"

module rmsi_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              drive_valid,
  input logic                              drive_enable,
  input logic                              drive_halt,
  input logic                              estop_latched,
  input logic                              all_clear,
  input logic [rmsi_pkg::HAZARD_WIDTH-1:0] hazard_mask,
  input logic [rmsi_pkg::HAZARD_WIDTH-1:0] new_hazard_mask,
  input logic [rmsi_pkg::HAZARD_WIDTH-1:0] cleared_mask
);

  // Conditions that a result beat has to meet
  logic                            halt_ok;
  logic                            enable_ok;
  logic                            masks_ok;
  logic                            stalled;
  logic [rmsi_pkg::HAZARD_WIDTH:0] held_view;

  assign halt_ok   = drive_valid && estop_latched;
  assign enable_ok = drive_valid && all_clear && (hazard_mask == '0);
  assign masks_ok  = ((new_hazard_mask & ~hazard_mask) == '0) &&
                     ((cleared_mask & hazard_mask) == '0);
  assign stalled   = out_valid && !out_ready;
  assign held_view = {hazard_mask, estop_latched};

  // No result beat right after reset
  `RMSI_ASSERT_ALWAYS(a_idle_after_reset, $past(rst) |-> !out_valid, "result beat after reset")

  // A halt pulse comes only with a drive update and a latched stop
  `RMSI_ASSERT(a_halt_latches, (out_valid && drive_halt) |-> halt_ok, "halt without latch")

  // Enabled drive means no hazard is active
  `RMSI_ASSERT(a_enable_clear, (out_valid && drive_enable) |-> enable_ok, "enable with hazard")

  // New hazards are active, cleared ones are not
  `RMSI_ASSERT(a_mask_consistent, out_valid |-> masks_ok, "hazard masks disagree")

  // A stalled result holds
  `RMSI_ASSERT(a_stall_holds, stalled |=> (out_valid && $stable(held_view)), "stall changed")

endmodule

bind robot_motion_safety_interlock_core rmsi_checker u_rmsi_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (drive.valid),
  .out_ready       (drive.ready),
  .drive_valid     (drive.drive_valid),
  .drive_enable    (drive.drive_enable),
  .drive_halt      (drive.drive_halt),
  .estop_latched   (drive.estop_latched),
  .all_clear       (drive.all_clear),
  .hazard_mask     (drive.hazard_mask),
  .new_hazard_mask (drive.new_hazard_mask),
  .cleared_mask    (drive.cleared_mask)
);
